// ===== sv/assert_macros.svh =====
// shared assertion macros, clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define LIK_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LIK_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/lik_pkg.sv =====
package lik_pkg;

    // field widths
    localparam int POS_W = 18;
    localparam int CFG_W = 16;
    localparam int ANG_W = 16;

    // cordic datapath widths
    localparam int CORD_W = 50;
    localparam int ACC_W  = 35;

    // parameter defaults
    localparam int CORDIC_STAGES_DEF   = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 13;

    // pi in Q30
    localparam logic signed [ACC_W-1:0] PI_Q30 = 35'sd3373259426;

    // register reset values
    localparam logic [CFG_W-1:0]        COXA_HEIGHT_RST  = 16'd1115;
    localparam logic [CFG_W-1:0]        HIP_LINK_RST     = 16'd2609;
    localparam logic [CFG_W-1:0]        FEMUR_LENGTH_RST = 16'd4592;
    localparam logic [CFG_W-1:0]        TIBIA_LENGTH_RST = 16'd7564;
    localparam logic signed [CFG_W-1:0] FEMUR_OFFSET_RST = 16'sd6554;
    localparam logic signed [CFG_W-1:0] TIBIA_OFFSET_RST = -16'sd20480;

    // register indexes
    typedef enum logic [2:0] {
        REG_COXA_HEIGHT        = 3'd0,
        REG_HIP_LINK_LENGTH    = 3'd1,
        REG_FEMUR_LENGTH       = 3'd2,
        REG_TIBIA_LENGTH       = 3'd3,
        REG_FEMUR_ANGLE_OFFSET = 3'd4,
        REG_TIBIA_ANGLE_OFFSET = 3'd5
    } reg_idx_t;

    // atan(2^-i) in Q30, truncated up to i = 26 and rounded above
    function automatic logic signed [ACC_W-1:0] atan_q30(input int i);
        logic signed [ACC_W-1:0] v;
        unique case (i)
            0:  v = 35'h3243F6A8;
            1:  v = 35'h1DAC6705;
            2:  v = 35'h0FADBAFC;
            3:  v = 35'h07F56EA6;
            4:  v = 35'h03FEAB76;
            5:  v = 35'h01FFD55B;
            6:  v = 35'h00FFFAAA;
            7:  v = 35'h007FFF55;
            8:  v = 35'h003FFFEA;
            9:  v = 35'h001FFFFD;
            10: v = 35'h000FFFFF;
            11: v = 35'h0007FFFF;
            12: v = 35'h0003FFFF;
            13: v = 35'h0001FFFF;
            14: v = 35'h0000FFFF;
            15: v = 35'h00007FFF;
            16: v = 35'h00003FFF;
            17: v = 35'h00001FFF;
            18: v = 35'h00000FFF;
            19: v = 35'h000007FF;
            20: v = 35'h000003FF;
            21: v = 35'h000001FF;
            22: v = 35'h000000FF;
            23: v = 35'h0000007F;
            24: v = 35'h0000003F;
            25: v = 35'h0000001F;
            26: v = 35'h0000000F;
            27: v = 35'h00000008;
            28: v = 35'h00000004;
            29: v = 35'h00000002;
            30: v = 35'h00000001;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/lik_isqrt.sv =====
module lik_isqrt #(
    parameter int IN_W  = 36,
    parameter int TAG_W = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                ce,
    input  logic                in_valid,
    input  logic [IN_W-1:0]     in_rad,
    input  logic [TAG_W-1:0]    in_tag,
    output logic                out_valid,
    output logic [IN_W/2-1:0]   out_root,
    output logic [TAG_W-1:0]    out_tag
);
    localparam int N = IN_W / 2;
    localparam logic [IN_W-1:0] ONE_W = 1;

    logic              valid_reg [N+1];
    logic [IN_W-1:0]   v_reg     [N+1];
    logic [IN_W-1:0]   r_reg     [N+1];
    logic [TAG_W-1:0]  tag_reg   [N+1];

    logic [IN_W:0]     t_sum  [N];
    logic [IN_W-1:0]   v_next [N];
    logic [IN_W-1:0]   r_next [N];

    // one root bit per stage, test bit walks down two places each step
    always_comb
    begin
        for (int k = 0; k < N; k++)
        begin
            t_sum[k] = {1'b0, r_reg[k]} + {1'b0, ONE_W << (2 * (N - 1 - k))};
            if ({1'b0, v_reg[k]} >= t_sum[k])
            begin
                v_next[k] = v_reg[k] - t_sum[k][IN_W-1:0];
                r_next[k] = (r_reg[k] >> 1) + (ONE_W << (2 * (N - 1 - k)));
            end
            else
            begin
                v_next[k] = v_reg[k];
                r_next[k] = r_reg[k] >> 1;
            end
        end
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= N; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (ce)
        begin
            valid_reg[0] <= in_valid;
            for (int k = 0; k < N; k++)
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            v_reg[0]   <= in_rad;
            r_reg[0]   <= '0;
            tag_reg[0] <= in_tag;
            for (int k = 0; k < N; k++)
            begin
                v_reg[k+1]   <= v_next[k];
                r_reg[k+1]   <= r_next[k];
                tag_reg[k+1] <= tag_reg[k];
            end
        end
    end

    assign out_valid = valid_reg[N];
    assign out_root  = r_reg[N][N-1:0];
    assign out_tag   = tag_reg[N];

endmodule

// ===== sv/lik_div.sv =====
module lik_div #(
    parameter int W     = 34,
    parameter int QB    = 29,
    parameter int TAG_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              ce,
    input  logic              in_valid,
    input  logic [W-1:0]      in_mag,
    input  logic [W-1:0]      in_den,
    input  logic [TAG_W-1:0]  in_tag,
    output logic              out_valid,
    output logic [QB-1:0]     out_quot,
    output logic [TAG_W-1:0]  out_tag
);
    logic              valid_reg [QB+1];
    logic [W-1:0]      r_reg     [QB+1];
    logic [W-1:0]      d_reg     [QB+1];
    logic [QB-1:0]     q_reg     [QB+1];
    logic [TAG_W-1:0]  tag_reg   [QB+1];

    logic [W:0]        r2     [QB];
    logic [W:0]        diff   [QB];
    logic              ge     [QB];
    logic [W-1:0]      r_next [QB];

    // restoring long division of mag / den, numerator <= denominator,
    // first step gives the integer bit, the rest give fraction bits
    always_comb
    begin
        for (int k = 0; k < QB; k++)
        begin
            if (k == 0)
            begin
                r2[k] = {1'b0, r_reg[k]};
            end
            else
            begin
                r2[k] = {r_reg[k], 1'b0};
            end
            diff[k]   = r2[k] - {1'b0, d_reg[k]};
            ge[k]     = r2[k] >= {1'b0, d_reg[k]};
            r_next[k] = ge[k] ? diff[k][W-1:0] : r2[k][W-1:0];
        end
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= QB; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (ce)
        begin
            valid_reg[0] <= in_valid;
            for (int k = 0; k < QB; k++)
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            r_reg[0]   <= in_mag;
            d_reg[0]   <= in_den;
            q_reg[0]   <= '0;
            tag_reg[0] <= in_tag;
            for (int k = 0; k < QB; k++)
            begin
                r_reg[k+1]   <= r_next[k];
                d_reg[k+1]   <= d_reg[k];
                q_reg[k+1]   <= {q_reg[k][QB-2:0], ge[k]};
                tag_reg[k+1] <= tag_reg[k];
            end
        end
    end

    assign out_valid = valid_reg[QB];
    assign out_quot  = q_reg[QB];
    assign out_tag   = tag_reg[QB];

endmodule

// ===== sv/lik_cordic.sv =====
`include "assert_macros.svh"

module lik_cordic #(
    parameter int LANES  = 4,
    parameter int STAGES = lik_pkg::CORDIC_STAGES_DEF,
    parameter int TAG_W  = 1
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    ce,
    input  logic                                    in_valid,
    input  logic [LANES-1:0][lik_pkg::CORD_W-1:0]   in_x,
    input  logic [LANES-1:0][lik_pkg::CORD_W-1:0]   in_y,
    input  logic [TAG_W-1:0]                        in_tag,
    output logic                                    out_valid,
    output logic [LANES-1:0][lik_pkg::ACC_W-1:0]    out_acc,
    output logic [TAG_W-1:0]                        out_tag
);
    import lik_pkg::*;

    logic                      valid_reg [STAGES+1];
    logic signed [CORD_W-1:0]  x_reg     [STAGES+1][LANES];
    logic signed [CORD_W-1:0]  y_reg     [STAGES+1][LANES];
    logic signed [ACC_W-1:0]   acc_reg   [STAGES+1][LANES];
    logic [TAG_W-1:0]          tag_reg   [STAGES+1];

    logic signed [CORD_W-1:0]  pre_x   [LANES];
    logic signed [CORD_W-1:0]  pre_y   [LANES];
    logic signed [ACC_W-1:0]   pre_acc [LANES];

    logic signed [CORD_W-1:0]  x_next   [STAGES][LANES];
    logic signed [CORD_W-1:0]  y_next   [STAGES][LANES];
    logic signed [ACC_W-1:0]   acc_next [STAGES][LANES];

    // left half plane: turn by pi, sign picked from the turned y
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if ($signed(in_x[l]) < 0)
            begin
                pre_x[l]   = -$signed(in_x[l]);
                pre_y[l]   = -$signed(in_y[l]);
                pre_acc[l] = (-$signed(in_y[l]) <= 0) ? PI_Q30 : -PI_Q30;
            end
            else
            begin
                pre_x[l]   = $signed(in_x[l]);
                pre_y[l]   = $signed(in_y[l]);
                pre_acc[l] = '0;
            end
        end
    end

    // vectoring micro-rotations, a stage with y at zero passes through
    always_comb
    begin
        for (int k = 0; k < STAGES; k++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                if (y_reg[k][l] > 0)
                begin
                    x_next[k][l]   = x_reg[k][l] + (y_reg[k][l] >>> k);
                    y_next[k][l]   = y_reg[k][l] - (x_reg[k][l] >>> k);
                    acc_next[k][l] = acc_reg[k][l] + atan_q30(k);
                end
                else if (y_reg[k][l] < 0)
                begin
                    x_next[k][l]   = x_reg[k][l] - (y_reg[k][l] >>> k);
                    y_next[k][l]   = y_reg[k][l] + (x_reg[k][l] >>> k);
                    acc_next[k][l] = acc_reg[k][l] - atan_q30(k);
                end
                else
                begin
                    x_next[k][l]   = x_reg[k][l];
                    y_next[k][l]   = y_reg[k][l];
                    acc_next[k][l] = acc_reg[k][l];
                end
            end
        end
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= STAGES; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (ce)
        begin
            valid_reg[0] <= in_valid;
            for (int k = 0; k < STAGES; k++)
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            tag_reg[0] <= in_tag;
            for (int l = 0; l < LANES; l++)
            begin
                x_reg[0][l]   <= pre_x[l];
                y_reg[0][l]   <= pre_y[l];
                acc_reg[0][l] <= pre_acc[l];
            end
            for (int k = 0; k < STAGES; k++)
            begin
                tag_reg[k+1] <= tag_reg[k];
                for (int l = 0; l < LANES; l++)
                begin
                    x_reg[k+1][l]   <= x_next[k][l];
                    y_reg[k+1][l]   <= y_next[k][l];
                    acc_reg[k+1][l] <= acc_next[k][l];
                end
            end
        end
    end

    // outputs
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            out_acc[l] = acc_reg[STAGES][l];
        end
    end
    assign out_valid = valid_reg[STAGES];
    assign out_tag   = tag_reg[STAGES];

    // checks
    for (genvar l = 0; l < LANES; l++)
    begin : g_chk
        `LIK_ASSERT_IMP(a_pre_right_half, valid_reg[0], !x_reg[0][l][CORD_W-1],
            "vector left of the y axis after the pi turn")
        `LIK_ASSERT_NXT(a_zero_y_settles, ce && (y_reg[STAGES-1][l] == '0),
            (y_reg[STAGES][l] == '0) && (acc_reg[STAGES][l] == $past(acc_reg[STAGES-1][l])),
            "stage moved a vector that had already reached the x axis")
    end

endmodule

// ===== sv/leg_inverse_kinematics_core.sv =====
// Three-joint leg inverse kinematics. Each input beat carries a foot target
// (x, y, z) in 2^-16 m; each output beat carries hip, femur and tibia angles
// in signed Q(ANGLE_FRAC_BITS) radians with the configured offsets added and
// saturated to 16 bits, plus an unreachable flag in tuser when the knee acos
// argument fell outside [-1, 1] and was clamped. The core is a full pipeline:
// one target is accepted every clock unless the output stalls, and each result
// passes through an 18-step planar square root, a 29-step fraction divider, a
// 29-step square root for the knee sine and the shared four-lane CORDIC
// vectoring unit. A stall on the output freezes the whole pipeline. Registers
// are written through the cfg channel, which is always ready; write them only
// while no target is in flight.
`include "assert_macros.svh"

module leg_inverse_kinematics_core #(
    parameter int CORDIC_STAGES   = lik_pkg::CORDIC_STAGES_DEF,
    parameter int ANGLE_FRAC_BITS = lik_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // target beat
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [55:0]                   s_axis_tdata,  // target_x, target_y, target_z, pad
    // angle beat
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [47:0]                   m_axis_tdata,  // hip_angle, femur_angle, tibia_angle
    output logic                          m_axis_tuser,  // unreachable
    // register writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  lik_pkg::reg_idx_t             cfg_index,
    input  logic [lik_pkg::CFG_W-1:0]     cfg_data
);
    import lik_pkg::*;

    localparam int SH = 30 - ANGLE_FRAC_BITS;
    localparam logic signed [37:0] RND = 38'sd1 <<< (SH - 1);
    localparam logic signed [29:0] ONE_C = 30'sd268435456;
    localparam logic [57:0] ONE_SQ = 58'd1 << 56;
    localparam int T1_W = 55;
    localparam int T2_W = 78;
    localparam int T3_W = 105;

    // saturate to the angle range
    function automatic logic [ANG_W-1:0] sat_ang(input logic signed [37:0] v);
        logic [ANG_W-1:0] r;
        if (v > 38'sd32767)
        begin
            r = 16'h7FFF;
        end
        else if (v < -38'sd32768)
        begin
            r = 16'h8000;
        end
        else
        begin
            r = v[ANG_W-1:0];
        end
        return r;
    endfunction

    logic ce;

    // config registers
    logic [CFG_W-1:0]        coxa_height_reg;
    logic [CFG_W-1:0]        hip_link_length_reg;
    logic [CFG_W-1:0]        femur_length_reg;
    logic [CFG_W-1:0]        tibia_length_reg;
    logic signed [CFG_W-1:0] femur_angle_offset_reg;
    logic signed [CFG_W-1:0] tibia_angle_offset_reg;

    // stage registers
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg, v9_reg;
    logic v10_reg, v11_reg, vo_reg;

    logic signed [17:0] s1_x_reg, s1_y_reg;
    logic [35:0]        s1_xx_reg, s1_yy_reg;
    logic signed [18:0] s1_zc_reg;

    logic [35:0]        s2_sum_reg;
    logic [T1_W-1:0]    s2_tag_reg;

    logic signed [17:0] s3_x_reg, s3_y_reg;
    logic signed [18:0] s3_zc_reg, s3_yc_reg;

    logic signed [17:0] s4_x_reg, s4_y_reg;
    logic signed [18:0] s4_zc_reg, s4_yc_reg;
    logic [36:0]        s4_yc2_reg, s4_zc2_reg;
    logic [31:0]        s4_l22_reg, s4_l33_reg, s4_l23_reg;

    logic signed [17:0] s5_x_reg, s5_y_reg;
    logic signed [18:0] s5_zc_reg, s5_yc_reg;
    logic signed [38:0] s5_num_reg;
    logic [33:0]        s5_den_reg;

    logic [33:0]        s6_mag_reg, s6_den_reg;
    logic [T2_W-1:0]    s6_tag_reg;

    logic signed [17:0] s7_x_reg, s7_y_reg;
    logic signed [18:0] s7_zc_reg, s7_yc_reg;
    logic signed [29:0] s7_c_reg;
    logic               s7_unr_reg;

    logic signed [17:0] s8_x_reg, s8_y_reg;
    logic signed [18:0] s8_zc_reg, s8_yc_reg;
    logic signed [29:0] s8_c_reg;
    logic               s8_unr_reg;
    logic [56:0]        s8_c2_reg;

    logic [57:0]        s9_rad_reg;
    logic [T3_W-1:0]    s9_tag_reg;

    logic signed [17:0] s10_x_reg, s10_y_reg;
    logic signed [18:0] s10_zc_reg, s10_yc_reg;
    logic signed [29:0] s10_c_reg;
    logic [28:0]        s10_s_reg;
    logic               s10_unr_reg;
    logic [44:0]        s10_ls_reg;
    logic signed [46:0] s10_lc_reg;

    logic [3:0][CORD_W-1:0] s11_lx_reg, s11_ly_reg;
    logic                   s11_unr_reg;

    logic [ANG_W-1:0]   hip_reg, femur_reg, tibia_reg;
    logic               unr_reg;

    // unit ports
    logic               q1_valid;
    logic [17:0]        q1_root;
    logic [T1_W-1:0]    q1_tag;
    logic               d_valid;
    logic [28:0]        d_quot;
    logic [T2_W-1:0]    d_tag;
    logic               q2_valid;
    logic [28:0]        q2_root;
    logic [T3_W-1:0]    q2_tag;
    logic               c_valid;
    logic [3:0][ACC_W-1:0] c_acc;
    logic               c_tag;

    // combinational helpers
    logic signed [17:0] in_x, in_y, in_z;
    logic signed [35:0] xx_full, yy_full;
    logic signed [37:0] yc2_full, zc2_full;
    logic signed [38:0] den_s, mag_full;
    logic               gt_w, lt_w;
    logic signed [29:0] c_w;
    logic signed [59:0] c2_full;
    logic signed [46:0] lc_full;
    logic signed [46:0] ax_w;
    logic signed [37:0] hip_w, fem_w, tib_w;

    // whole pipeline advances unless the output beat is held
    assign ce            = !vo_reg || m_axis_tready;
    assign s_axis_tready = ce;
    assign cfg_ready     = 1'b1;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coxa_height_reg        <= COXA_HEIGHT_RST;
            hip_link_length_reg    <= HIP_LINK_RST;
            femur_length_reg       <= FEMUR_LENGTH_RST;
            tibia_length_reg       <= TIBIA_LENGTH_RST;
            femur_angle_offset_reg <= FEMUR_OFFSET_RST;
            tibia_angle_offset_reg <= TIBIA_OFFSET_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_COXA_HEIGHT:        coxa_height_reg        <= cfg_data;
                REG_HIP_LINK_LENGTH:    hip_link_length_reg    <= cfg_data;
                REG_FEMUR_LENGTH:       femur_length_reg       <= cfg_data;
                REG_TIBIA_LENGTH:       tibia_length_reg       <= cfg_data;
                REG_FEMUR_ANGLE_OFFSET: femur_angle_offset_reg <= $signed(cfg_data);
                REG_TIBIA_ANGLE_OFFSET: tibia_angle_offset_reg <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    // input unpack and squares
    assign in_x    = $signed(s_axis_tdata[17:0]);
    assign in_y    = $signed(s_axis_tdata[35:18]);
    assign in_z    = $signed(s_axis_tdata[53:36]);
    assign xx_full = in_x * in_x;
    assign yy_full = in_y * in_y;

    // leg plane squares
    assign yc2_full = s3_yc_reg * s3_yc_reg;
    assign zc2_full = s3_zc_reg * s3_zc_reg;

    // clamp decision on the cosine numerator
    assign den_s    = $signed({5'b0, s5_den_reg});
    assign gt_w     = s5_num_reg > den_s;
    assign lt_w     = s5_num_reg < -den_s;
    assign mag_full = s5_num_reg[38] ? -s5_num_reg : s5_num_reg;

    // cosine in Q28 from divider result and clamp flags
    always_comb
    begin
        priority if (d_tag[77])
        begin
            c_w = ONE_C;
        end
        else if (d_tag[76])
        begin
            c_w = -ONE_C;
        end
        else if (d_tag[75])
        begin
            c_w = '0;
        end
        else if (d_tag[74])
        begin
            c_w = -$signed({1'b0, d_quot});
        end
        else
        begin
            c_w = $signed({1'b0, d_quot});
        end
    end

    assign c2_full = s7_c_reg * s7_c_reg;
    assign lc_full = $signed({1'b0, tibia_length_reg}) * $signed(q2_tag[103:74]);
    assign ax_w    = $signed({3'b0, femur_length_reg, 28'b0}) + s10_lc_reg;

    // rounding to output format and offsets
    assign hip_w = (38'($signed(c_acc[0])) + RND) >>> SH;
    assign fem_w = ((38'($signed(c_acc[1])) + 38'($signed(c_acc[2])) + RND) >>> SH)
                   + 38'(femur_angle_offset_reg);
    assign tib_w = ((38'($signed(c_acc[3])) + RND) >>> SH) + 38'(tibia_angle_offset_reg);

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            v5_reg  <= 1'b0;
            v6_reg  <= 1'b0;
            v7_reg  <= 1'b0;
            v8_reg  <= 1'b0;
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
            v11_reg <= 1'b0;
            vo_reg  <= 1'b0;
        end
        else if (ce)
        begin
            v1_reg  <= s_axis_tvalid;
            v2_reg  <= v1_reg;
            v3_reg  <= q1_valid;
            v4_reg  <= v3_reg;
            v5_reg  <= v4_reg;
            v6_reg  <= v5_reg;
            v7_reg  <= d_valid;
            v8_reg  <= v7_reg;
            v9_reg  <= v8_reg;
            v10_reg <= q2_valid;
            v11_reg <= v10_reg;
            vo_reg  <= c_valid;
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            // target squares and lifted z
            s1_x_reg  <= in_x;
            s1_y_reg  <= in_y;
            s1_xx_reg <= xx_full;
            s1_yy_reg <= yy_full;
            s1_zc_reg <= $signed({in_z[17], in_z}) + $signed({3'b0, coxa_height_reg});

            // planar radius squared
            s2_sum_reg <= s1_xx_reg + s1_yy_reg;
            s2_tag_reg <= {s1_zc_reg, s1_y_reg, s1_x_reg};

            // reach minus hip link
            s3_x_reg  <= $signed(q1_tag[17:0]);
            s3_y_reg  <= $signed(q1_tag[35:18]);
            s3_zc_reg <= $signed(q1_tag[54:36]);
            s3_yc_reg <= $signed({1'b0, q1_root}) - $signed({3'b0, hip_link_length_reg});

            // squares
            s4_x_reg   <= s3_x_reg;
            s4_y_reg   <= s3_y_reg;
            s4_zc_reg  <= s3_zc_reg;
            s4_yc_reg  <= s3_yc_reg;
            s4_yc2_reg <= yc2_full[36:0];
            s4_zc2_reg <= zc2_full[36:0];
            s4_l22_reg <= femur_length_reg * femur_length_reg;
            s4_l33_reg <= tibia_length_reg * tibia_length_reg;
            s4_l23_reg <= femur_length_reg * tibia_length_reg;

            // law of cosines numerator and denominator
            s5_x_reg   <= s4_x_reg;
            s5_y_reg   <= s4_y_reg;
            s5_zc_reg  <= s4_zc_reg;
            s5_yc_reg  <= s4_yc_reg;
            s5_num_reg <= $signed({2'b0, s4_yc2_reg}) + $signed({2'b0, s4_zc2_reg})
                          - $signed({7'b0, s4_l22_reg}) - $signed({7'b0, s4_l33_reg});
            s5_den_reg <= {1'b0, s4_l23_reg, 1'b0};

            // divider operands and clamp flags
            s6_mag_reg <= mag_full[33:0];
            s6_den_reg <= s5_den_reg;
            s6_tag_reg <= {gt_w, lt_w, (s5_den_reg == '0), s5_num_reg[38],
                           s5_yc_reg, s5_zc_reg, s5_y_reg, s5_x_reg};

            // cosine
            s7_x_reg   <= $signed(d_tag[17:0]);
            s7_y_reg   <= $signed(d_tag[35:18]);
            s7_zc_reg  <= $signed(d_tag[54:36]);
            s7_yc_reg  <= $signed(d_tag[73:55]);
            s7_c_reg   <= c_w;
            s7_unr_reg <= d_tag[77] | d_tag[76];

            // cosine squared
            s8_x_reg   <= s7_x_reg;
            s8_y_reg   <= s7_y_reg;
            s8_zc_reg  <= s7_zc_reg;
            s8_yc_reg  <= s7_yc_reg;
            s8_c_reg   <= s7_c_reg;
            s8_unr_reg <= s7_unr_reg;
            s8_c2_reg  <= c2_full[56:0];

            // one minus cosine squared
            s9_rad_reg <= ONE_SQ - {1'b0, s8_c2_reg};
            s9_tag_reg <= {s8_unr_reg, s8_c_reg, s8_yc_reg, s8_zc_reg, s8_y_reg, s8_x_reg};

            // tibia length times sine and cosine
            s10_x_reg   <= $signed(q2_tag[17:0]);
            s10_y_reg   <= $signed(q2_tag[35:18]);
            s10_zc_reg  <= $signed(q2_tag[54:36]);
            s10_yc_reg  <= $signed(q2_tag[73:55]);
            s10_c_reg   <= $signed(q2_tag[103:74]);
            s10_unr_reg <= q2_tag[104];
            s10_s_reg   <= q2_root;
            s10_ls_reg  <= tibia_length_reg * q2_root;
            s10_lc_reg  <= lc_full;

            // cordic lanes: hip, plane angle, femur correction, knee
            s11_lx_reg[0] <= CORD_W'(s10_y_reg);
            s11_ly_reg[0] <= -CORD_W'(s10_x_reg);
            s11_lx_reg[1] <= CORD_W'(s10_yc_reg);
            s11_ly_reg[1] <= CORD_W'(s10_zc_reg);
            s11_lx_reg[2] <= CORD_W'(ax_w);
            s11_ly_reg[2] <= {5'b0, s10_ls_reg};
            s11_lx_reg[3] <= CORD_W'(s10_c_reg);
            s11_ly_reg[3] <= {21'b0, s10_s_reg};
            s11_unr_reg   <= s10_unr_reg;

            // output beat
            hip_reg   <= sat_ang(hip_w);
            femur_reg <= sat_ang(fem_w);
            tibia_reg <= sat_ang(tib_w);
            unr_reg   <= c_tag;
        end
    end

    // planar reach
    lik_isqrt #(
        .IN_W  (36),
        .TAG_W (T1_W)
    ) u_reach_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (v2_reg),
        .in_rad    (s2_sum_reg),
        .in_tag    (s2_tag_reg),
        .out_valid (q1_valid),
        .out_root  (q1_root),
        .out_tag   (q1_tag)
    );

    // cosine fraction
    lik_div #(
        .W     (34),
        .QB    (29),
        .TAG_W (T2_W)
    ) u_cos_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (v6_reg),
        .in_mag    (s6_mag_reg),
        .in_den    (s6_den_reg),
        .in_tag    (s6_tag_reg),
        .out_valid (d_valid),
        .out_quot  (d_quot),
        .out_tag   (d_tag)
    );

    // knee sine
    lik_isqrt #(
        .IN_W  (58),
        .TAG_W (T3_W)
    ) u_sine_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (v9_reg),
        .in_rad    (s9_rad_reg),
        .in_tag    (s9_tag_reg),
        .out_valid (q2_valid),
        .out_root  (q2_root),
        .out_tag   (q2_tag)
    );

    // all four angles
    lik_cordic #(
        .LANES  (4),
        .STAGES (CORDIC_STAGES),
        .TAG_W  (1)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (v11_reg),
        .in_x      (s11_lx_reg),
        .in_y      (s11_ly_reg),
        .in_tag    (s11_unr_reg),
        .out_valid (c_valid),
        .out_acc   (c_acc),
        .out_tag   (c_tag)
    );

    assign m_axis_tvalid = vo_reg;
    assign m_axis_tdata  = {tibia_reg, femur_reg, hip_reg};
    assign m_axis_tuser  = unr_reg;

    // a clamped cosine must leave a zero sine after the square root
    `LIK_ASSERT_IMP(a_clamp_sine_zero, q2_valid && q2_tag[104], q2_root == '0,
        "clamped cosine produced a nonzero sine")

endmodule
